@@ src/log_record_deframer_checker_macros.svh @@
// ----------------------------------------------------------------------------
// log_record_deframer_checker_macros.svh
// Assertion macros for the record deframer; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LOG_RECORD_DEFRAMER_CHECKER_MACROS_SVH
`define LOG_RECORD_DEFRAMER_CHECKER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define LRDC_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define LRDC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LRDC_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`define LRDC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ src/lrdc_pkg.sv @@
// ----------------------------------------------------------------------------
// lrdc_pkg
// Shared types, codes and the FNV-1a-32 step for the record deframer.
// ----------------------------------------------------------------------------
package lrdc_pkg;

  localparam logic [31:0] FnvBasis   = 32'd2166136261;
  localparam logic [31:0] FnvPrime   = 32'd16777619;
  localparam int unsigned SeqBytes   = 8;
  localparam int unsigned CheckBytes = 4;
  localparam int unsigned QueueDepth = 2;

  // result codes
  localparam logic [2:0] KindKey     = 3'd0;
  localparam logic [2:0] KindValue   = 3'd1;
  localparam logic [2:0] KindAccept  = 3'd2;
  localparam logic [2:0] KindReject  = 3'd3;
  localparam logic [2:0] KindSummary = 3'd4;

  // front-end phase, one-hot
  typedef enum logic [6:0] {
    PhSeq   = 7'b0000001,
    PhOp    = 7'b0000010,
    PhKlen  = 7'b0000100,
    PhKey   = 7'b0001000,
    PhVlen  = 7'b0010000,
    PhVal   = 7'b0100000,
    PhCheck = 7'b1000000
  } lrdc_phase_e;

  // classified byte handed from front to back
  typedef enum logic [3:0] {
    CmdSeq   = 4'd0,
    CmdOp    = 4'd1,
    CmdKlen  = 4'd2,
    CmdKey   = 4'd3,
    CmdVlen  = 4'd4,
    CmdVal   = 4'd5,
    CmdCheck = 4'd6,
    CmdEol   = 4'd7
  } lrdc_cmd_e;

  typedef struct packed {
    lrdc_cmd_e   op;
    logic [7:0]  data;
    logic [2:0]  idx;      // byte lane within the field
    logic        partial;  // end of log: front was inside a record
  } lrdc_entry_t;

  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'h000000, b};
    return x * FnvPrime;
  endfunction

endpackage

@@ src/log_record_deframer_checker.sv @@
// ----------------------------------------------------------------------------
// log_record_deframer_checker
// Splits a byte-wide write-ahead log into records, passes key and value
// bytes through and checks each record's FNV-1a-32 checksum until the first
// mismatch, and reports a replay summary at end of log.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   -------   ---------  ---------------------  ----------------------------
//   in        sink       in_valid_i/in_ready_o  kind_i, log_byte_i
//   out       source     out_valid_o/out_ready_i out_kind_o .. partial_pending_o
//
// One transaction per cycle sustained while the queue is not full. The front
// is combinational and writes each accepted transaction to the 2-entry queue
// at its accepting edge; the back pops it from the queue head and loads the
// result register at that popping edge. A waiting result holds entries that
// give results; two of those fill the queue and drop in_ready_o.
// Reset (rst_ni, asynchronous) clears all framing, hash and replay state.
// ----------------------------------------------------------------------------
module log_record_deframer_checker #(
  parameter int unsigned LENGTH_BYTES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  log_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  out_kind_o,
  output logic [7:0]  data_byte_o,
  output logic [63:0] record_sequence_o,
  output logic [7:0]  record_op_o,
  output logic [31:0] key_length_o,
  output logic [31:0] value_length_o,
  output logic [63:0] highest_sequence_o,
  output logic [31:0] records_accepted_o,
  output logic        partial_pending_o
);
  import lrdc_pkg::*;

  logic        in_accept;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  lrdc_entry_t front_entry;
  lrdc_entry_t q_head;

  // input side stalls only on a full queue, never on the output directly
  assign in_ready_o = !q_full;
  assign in_accept  = in_valid_i && !q_full;

  // front: framing; every transaction becomes exactly one queue entry
  lrdc_front #(
    .LENGTH_BYTES(LENGTH_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .kind_i     (kind_i),
    .log_byte_i (log_byte_i),
    .entry_o    (front_entry)
  );

  lrdc_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (front_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_head)
  );

  // back: hash and checksum compare, summary totals, result register;
  // entries that give no result drain even while the output is held
  lrdc_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_valid_i       (q_valid),
    .head_i             (q_head),
    .pop_o              (q_pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_kind_o         (out_kind_o),
    .data_byte_o        (data_byte_o),
    .record_sequence_o  (record_sequence_o),
    .record_op_o        (record_op_o),
    .key_length_o       (key_length_o),
    .value_length_o     (value_length_o),
    .highest_sequence_o (highest_sequence_o),
    .records_accepted_o (records_accepted_o),
    .partial_pending_o  (partial_pending_o)
  );

endmodule

@@ src/lrdc_front.sv @@
// ----------------------------------------------------------------------------
// lrdc_front
// Tracks record framing and tags each accepted byte with its field and lane.
// ----------------------------------------------------------------------------
module lrdc_front #(
  parameter int unsigned LENGTH_BYTES = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 kind_i,
  input  logic [7:0]           log_byte_i,
  output lrdc_pkg::lrdc_entry_t entry_o
);
  import lrdc_pkg::*;

  lrdc_phase_e phase_q, phase_d;
  logic [31:0] count_q, count_d;
  logic [31:0] klen_q, klen_d;
  logic [31:0] vlen_q, vlen_d;
  logic [31:0] count_inc;
  lrdc_entry_t entry;

  assign count_inc = count_q + 32'd1;

  always_comb begin
    phase_d       = phase_q;
    count_d       = count_q;
    klen_d        = klen_q;
    vlen_d        = vlen_q;
    entry.op      = CmdSeq;
    entry.data    = log_byte_i;
    entry.idx     = count_q[2:0];
    entry.partial = 1'b0;
    if (kind_i) begin
      entry.op      = CmdEol;
      entry.partial = !((phase_q == PhSeq) && (count_q == 32'd0));
      phase_d       = PhSeq;
      count_d       = '0;
      klen_d        = '0;
      vlen_d        = '0;
    end else begin
      case (phase_q)
        PhSeq: begin
          entry.op = CmdSeq;
          if (count_q == 32'(SeqBytes - 1)) begin
            count_d = '0;
            phase_d = PhOp;
          end else begin
            count_d = count_inc;
          end
        end
        PhOp: begin
          entry.op = CmdOp;
          count_d  = '0;
          phase_d  = PhKlen;
        end
        PhKlen: begin
          entry.op = CmdKlen;
          klen_d[{count_q[1:0], 3'b000} +: 8] = log_byte_i;
          if (count_q == 32'(LENGTH_BYTES - 1)) begin
            count_d = '0;
            phase_d = (klen_d == 32'd0) ? PhVlen : PhKey;
          end else begin
            count_d = count_inc;
          end
        end
        PhKey: begin
          entry.op = CmdKey;
          if (count_inc == klen_q) begin
            count_d = '0;
            phase_d = PhVlen;
          end else begin
            count_d = count_inc;
          end
        end
        PhVlen: begin
          entry.op = CmdVlen;
          vlen_d[{count_q[1:0], 3'b000} +: 8] = log_byte_i;
          if (count_q == 32'(LENGTH_BYTES - 1)) begin
            count_d = '0;
            phase_d = (vlen_d == 32'd0) ? PhCheck : PhVal;
          end else begin
            count_d = count_inc;
          end
        end
        PhVal: begin
          entry.op = CmdVal;
          if (count_inc == vlen_q) begin
            count_d = '0;
            phase_d = PhCheck;
          end else begin
            count_d = count_inc;
          end
        end
        PhCheck: begin
          entry.op = CmdCheck;
          if (count_q == 32'(CheckBytes - 1)) begin
            // back decides accept/reject; framing restarts either way
            count_d = '0;
            klen_d  = '0;
            vlen_d  = '0;
            phase_d = PhSeq;
          end else begin
            count_d = count_inc;
          end
        end
        default: begin
          phase_d = PhSeq;
          count_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSeq;
      count_q <= '0;
      klen_q  <= '0;
      vlen_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      klen_q  <= klen_d;
      vlen_q  <= vlen_d;
    end
  end

  assign entry_o = entry;

endmodule

@@ src/lrdc_queue.sv @@
// ----------------------------------------------------------------------------
// lrdc_queue
// Small FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
`include "log_record_deframer_checker_macros.svh"

module lrdc_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  lrdc_pkg::lrdc_entry_t push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output lrdc_pkg::lrdc_entry_t pop_data_o
);
  import lrdc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  lrdc_entry_t          mem_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      count_q, count_d;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `LRDC_ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, pop_i, count_q != '0, "pop from empty queue")
  `LRDC_ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, push_i && !pop_i, !full_o, "push into full queue")

endmodule

@@ src/lrdc_back.sv @@
// ----------------------------------------------------------------------------
// lrdc_back
// Hash, checksum compare, replay totals and the result register.
// ----------------------------------------------------------------------------
`include "log_record_deframer_checker_macros.svh"

module lrdc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  lrdc_pkg::lrdc_entry_t head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            out_kind_o,
  output logic [7:0]            data_byte_o,
  output logic [63:0]           record_sequence_o,
  output logic [7:0]            record_op_o,
  output logic [31:0]           key_length_o,
  output logic [31:0]           value_length_o,
  output logic [63:0]           highest_sequence_o,
  output logic [31:0]           records_accepted_o,
  output logic                  partial_pending_o
);
  import lrdc_pkg::*;

  // record and replay state
  logic [63:0] seq_q, seq_d;
  logic [7:0]  op_q, op_d;
  logic [31:0] klen_q, klen_d;
  logic [31:0] vlen_q, vlen_d;
  logic [31:0] chk_q, chk_d;
  logic [31:0] hash_q, hash_d;
  logic [63:0] max_q, max_d;
  logic [31:0] acc_q, acc_d;
  logic        stopped_q, stopped_d;

  // result register
  logic        out_valid_q;
  logic [2:0]  out_kind_q;
  logic [7:0]  data_q;
  logic [63:0] rseq_q, hseq_q;
  logic [7:0]  rop_q;
  logic [31:0] rklen_q, rvlen_q, racc_q;
  logic        rpart_q;

  logic [2:0]  res_kind;
  logic        emit, load, slot_free, step;
  logic [7:0]  hash_byte;
  logic [31:0] hash_next;
  logic        chk_first, chk_last;

  assign chk_first = (head_i.idx == 3'd0);
  assign chk_last  = (head_i.idx == 3'(CheckBytes - 1));
  assign hash_byte = (head_i.op == CmdCheck) ? op_q : head_i.data;
  assign hash_next = fnv_step(hash_q, hash_byte);

  // does the head entry give a result
  always_comb begin
    emit = 1'b0;
    if (head_i.op == CmdEol) begin
      emit = 1'b1;
    end else if (!stopped_q) begin
      emit = (head_i.op == CmdKey) || (head_i.op == CmdVal) ||
             ((head_i.op == CmdCheck) && chk_last);
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;
  assign pop_o     = head_valid_i && (!emit || slot_free);
  assign load      = pop_o && emit;
  assign step      = pop_o && (!stopped_q || (head_i.op == CmdEol));

  always_comb begin
    seq_d     = seq_q;
    op_d      = op_q;
    klen_d    = klen_q;
    vlen_d    = vlen_q;
    chk_d     = chk_q;
    hash_d    = hash_q;
    max_d     = max_q;
    acc_d     = acc_q;
    stopped_d = stopped_q;
    res_kind  = KindKey;
    case (head_i.op)
      CmdSeq:  seq_d[{head_i.idx, 3'b000} +: 8] = head_i.data;
      CmdOp:   op_d = head_i.data;
      CmdKlen: klen_d[{head_i.idx[1:0], 3'b000} +: 8] = head_i.data;
      CmdVlen: vlen_d[{head_i.idx[1:0], 3'b000} +: 8] = head_i.data;
      CmdKey: begin
        res_kind = KindKey;
        hash_d   = hash_next;
      end
      CmdVal: begin
        res_kind = KindValue;
        hash_d   = hash_next;
      end
      CmdCheck: begin
        chk_d[{head_i.idx[1:0], 3'b000} +: 8] = head_i.data;
        // fold in the op on the first check byte so the compare is ready
        if (chk_first) begin
          hash_d = hash_next;
        end
        if (chk_last) begin
          if (hash_q == chk_d) begin
            res_kind = KindAccept;
            if (seq_q > max_q) begin
              max_d = seq_q;
            end
            if (acc_q != '1) begin
              acc_d = acc_q + 32'd1;
            end
            seq_d  = '0;
            op_d   = '0;
            klen_d = '0;
            vlen_d = '0;
            chk_d  = '0;
            hash_d = FnvBasis;
          end else begin
            res_kind  = KindReject;
            stopped_d = 1'b1;
          end
        end
      end
      CmdEol: begin
        res_kind  = KindSummary;
        seq_d     = '0;
        op_d      = '0;
        klen_d    = '0;
        vlen_d    = '0;
        chk_d     = '0;
        hash_d    = FnvBasis;
        max_d     = '0;
        acc_d     = '0;
        stopped_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q     <= '0;
      op_q      <= '0;
      klen_q    <= '0;
      vlen_q    <= '0;
      chk_q     <= '0;
      hash_q    <= FnvBasis;
      max_q     <= '0;
      acc_q     <= '0;
      stopped_q <= 1'b0;
    end else if (step) begin
      seq_q     <= seq_d;
      op_q      <= op_d;
      klen_q    <= klen_d;
      vlen_q    <= vlen_d;
      chk_q     <= chk_d;
      hash_q    <= hash_d;
      max_q     <= max_d;
      acc_q     <= acc_d;
      stopped_q <= stopped_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // unused fields of each result are zero
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_kind_q <= res_kind;
      data_q     <= ((res_kind == KindKey) || (res_kind == KindValue)) ? head_i.data : 8'h00;
      if ((res_kind == KindAccept) || (res_kind == KindReject)) begin
        rseq_q  <= seq_q;
        rop_q   <= op_q;
        rklen_q <= klen_q;
        rvlen_q <= vlen_q;
      end else begin
        rseq_q  <= '0;
        rop_q   <= '0;
        rklen_q <= '0;
        rvlen_q <= '0;
      end
      if (res_kind == KindSummary) begin
        hseq_q  <= max_q;
        racc_q  <= acc_q;
        rpart_q <= head_i.partial && !stopped_q;
      end else begin
        hseq_q  <= '0;
        racc_q  <= '0;
        rpart_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_kind_o         = out_kind_q;
  assign data_byte_o        = data_q;
  assign record_sequence_o  = rseq_q;
  assign record_op_o        = rop_q;
  assign key_length_o       = rklen_q;
  assign value_length_o     = rvlen_q;
  assign highest_sequence_o = hseq_q;
  assign records_accepted_o = racc_q;
  assign partial_pending_o  = rpart_q;

  `LRDC_ASSERT_IMPL(a_stopped_quiet, clk_i, rst_ni, stopped_q && pop_o && (head_i.op != CmdEol), !load, "result after rejection")
  `LRDC_ASSERT_NEXT(a_summary_clears, clk_i, rst_ni, load && (res_kind == KindSummary), !stopped_q && (hash_q == FnvBasis) && (acc_q == '0), "summary left state behind")

endmodule
